// ===== sv/ttli_pkg.sv =====
`timescale 1ns / 1ps
package ttli_pkg;
  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_VARS_DEF = 8;

  localparam logic [1:0] OP_STAMP = 2'd0;
  localparam logic [1:0] OP_VALUE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_REJ   = 2'd2;

  localparam logic CFG_ACTIVE = 1'b0;
  localparam logic CFG_MASK   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAST_RD,
    S_LAST_CHK,
    S_FIRST_RD,
    S_FIRST_CHK,
    S_CUR_RD,
    S_CUR_CHK,
    S_WALK_RD,
    S_WALK_CHK,
    S_LO_RD,
    S_DIV,
    S_VAL_RD,
    S_VAL_WAIT,
    S_VAL_EMIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

// ===== sv/ttli_ram.sv =====
`timescale 1ns / 1ps
module ttli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/ttli_div.sv =====
`timescale 1ns / 1ps
module ttli_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [47:0]          num,
  input  logic [32:0]          den,
  output ttli_pkg::div_ctl_t   ctl,
  output logic [16:0]          quo
);
  import ttli_pkg::*;

  // Restoring divider, one quotient bit per cycle. The quotient is known
  // to fit in 17 bits because num < (den << 16) + den.
  logic [48:0] rem_r, rem_nxt;
  logic [47:0] n_r, n_nxt;
  logic [32:0] d_r;
  logic [16:0] q_r, q_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [49:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    n_nxt    = n_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, n_r[47]} - {17'd0, d_r};
    if (start) begin
      rem_nxt  = '0;
      n_nxt    = num;
      q_nxt    = '0;
      cnt_nxt  = 6'd48;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[46:0], 1'b0};
      if (!trial[49]) begin
        rem_nxt = trial[48:0];
        q_nxt   = {q_r[15:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[47:0], n_r[47]};
        q_nxt   = {q_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    n_r   <= n_nxt;
    q_r   <= q_nxt;
    if (start) begin
      d_r <= den;
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;
  assign quo       = q_r;
endmodule

// ===== sv/time_table_linear_interpolator_core.sv =====
`timescale 1ns / 1ps
// Piecewise-linear time table. A query reads the first and last stamps and checks the
// cursor. It then walks forward through the stamp memory row by row. It runs a bit-serial
// divider for the fraction and emits one result per active variable, at least one (two
// value-memory reads per variable). A backward jump restarts the walk at row 0. A query
// outside the table skips the walk and the divider. Results sit in an output register; no
// new item is taken until the last result of the current one is delivered, and a stalled
// output holds up the next variable.
module time_table_linear_interpolator_core #(
  parameter int MAX_ROWS = ttli_pkg::MAX_ROWS_DEF,
  parameter int MAX_VARS = ttli_pkg::MAX_VARS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_row,
  input  logic [2:0]         in_variable,
  input  logic signed [31:0] in_data_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_variable,
  output logic signed [31:0] out_value,
  output logic [1:0]         out_status,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);
  import ttli_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = $clog2(MAX_ROWS * MAX_VARS);
  localparam int CW = RW + 1;

  state_t state_r, state_nxt;

  logic [3:0]  active_r;
  logic [7:0]  mask_r;
  logic [CW-1:0] rows_r, rows_nxt;
  logic [RW-1:0] cur_r, cur_nxt;

  logic [1:0]  op_r;
  logic [7:0]  row_r;
  logic [2:0]  var_in_r;
  logic signed [31:0] word_r;

  logic [RW-1:0] c_r, c_nxt;
  logic [RW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, disc_r, disc_nxt;
  logic signed [31:0] t2_r, t2_nxt, t1_r, t1_nxt;
  logic [16:0] lam_r, lam_nxt;
  logic        exact_r, exact_nxt;
  logic [2:0]  v_r, v_nxt;
  logic [2:0]  n_eff;
  logic signed [31:0] v1_r, v1_nxt;

  logic        ov_r, ov_nxt, olast_r, olast_nxt;
  logic [2:0]  ovar_r, ovar_nxt;
  logic signed [31:0] oval_r, oval_nxt;
  logic [1:0]  ost_r, ost_nxt;

  logic          s_we;
  logic [RW-1:0] s_waddr, s_raddr;
  logic [31:0]   s_rdata;
  logic          v_we;
  logic [AW-1:0] v_waddr, v_raddr;
  logic [31:0]   v_rdata;

  logic        div_start;
  logic        div_start_r;
  div_ctl_t    div_ctl;
  logic [16:0] div_q;
  logic [47:0] div_num;
  logic [32:0] div_den;

  logic signed [32:0] diff;
  logic signed [50:0] prod;
  logic signed [50:0] rnd;
  logic signed [31:0] blended;
  logic        is_cont;
  logic signed [31:0] srd;

  ttli_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_stamp (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(word_r),
    .raddr(s_raddr), .rdata(s_rdata)
  );
  ttli_ram #(.WIDTH(32), .DEPTH(MAX_ROWS * MAX_VARS)) u_value (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(word_r),
    .raddr(v_raddr), .rdata(v_rdata)
  );
  ttli_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(div_den), .ctl(div_ctl), .quo(div_q)
  );

  assign srd = $signed(s_rdata);
  // The query lies above t1, so the difference fits in 32 unsigned bits.
  assign div_num = {32'(word_r - t1_r), 16'd0};
  assign div_den = {t2_r[31], t2_r} - {t1_r[31], t1_r};

  always_comb begin
    if (active_r == 4'd0) n_eff = 3'd0;
    else if (32'(active_r) > MAX_VARS) n_eff = 3'(MAX_VARS - 1);
    else n_eff = 3'(active_r - 4'd1);
  end

  assign is_cont = mask_r[v_r];
  assign diff    = $signed({v_rdata[31], v_rdata}) - $signed({v1_r[31], v1_r});
  assign prod    = 51'(diff) * $signed({34'd0, lam_r});
  assign rnd     = (prod + 51'sd32768) >>> 16;
  assign blended = 32'(v1_r + 32'(rnd));

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_variable = ovar_r;
  assign out_value = oval_r;
  assign out_status = ost_r;
  assign out_last = olast_r;

  always_comb begin
    state_nxt = state_r;
    rows_nxt = rows_r;
    cur_nxt = cur_r;
    c_nxt = c_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    disc_nxt = disc_r;
    t1_nxt = t1_r;
    t2_nxt = t2_r;
    lam_nxt = lam_r;
    exact_nxt = exact_r;
    v_nxt = v_r;
    v1_nxt = v1_r;
    ov_nxt = ov_r;
    olast_nxt = olast_r;
    ovar_nxt = ovar_r;
    oval_nxt = oval_r;
    ost_nxt = ost_r;
    s_we = 1'b0;
    s_waddr = rows_r[RW-1:0];
    s_raddr = '0;
    v_we = 1'b0;
    v_waddr = AW'(32'(row_r) * MAX_VARS + 32'(var_in_r));
    v_raddr = '0;
    div_start = 1'b0;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_op)
            OP_STAMP: state_nxt = S_LAST_RD;
            OP_VALUE: begin
              if (32'(in_row) >= 32'(rows_r) || 32'(in_variable) >= MAX_VARS) begin
                ost_nxt = ST_REJ;
              end else begin
                ost_nxt = ST_OK;
              end
              ovar_nxt = '0; oval_nxt = '0; olast_nxt = 1'b1;
              state_nxt = S_OUT;
            end
            OP_QUERY: begin
              if (rows_r == '0) begin
                ovar_nxt = '0; oval_nxt = '0; olast_nxt = 1'b1; ost_nxt = ST_EMPTY;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_FIRST_RD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_OUT: begin
        // Value write happens here once the verdict is known.
        if (op_r == OP_VALUE && ost_r == ST_OK) v_we = 1'b1;
        if (op_r == OP_STAMP && ost_r == ST_OK) begin
          s_we = 1'b1;
          rows_nxt = rows_r + CW'(1);
        end
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_LAST_RD: begin
        s_raddr = RW'(rows_r - CW'(1));
        state_nxt = S_LAST_CHK;
      end
      S_LAST_CHK: begin
        ovar_nxt = '0; oval_nxt = '0; olast_nxt = 1'b1;
        if (32'(rows_r) >= MAX_ROWS || (rows_r != '0 && word_r <= srd)) ost_nxt = ST_REJ;
        else ost_nxt = ST_OK;
        state_nxt = S_OUT;
      end
      S_FIRST_RD: begin
        s_raddr = '0;
        state_nxt = S_FIRST_CHK;
      end
      S_FIRST_CHK: begin
        s_raddr = RW'(rows_r - CW'(1));
        if (word_r <= srd) begin
          lo_nxt = '0; hi_nxt = '0; disc_nxt = '0; lam_nxt = '0; cur_nxt = '0;
          v_nxt = '0; state_nxt = S_VAL_RD;
        end else begin
          state_nxt = S_CUR_RD;
        end
      end
      S_CUR_RD: begin
        // s_rdata holds the last stamp now.
        if (word_r >= srd) begin
          lo_nxt = RW'(rows_r - CW'(1)); hi_nxt = lo_nxt; disc_nxt = lo_nxt;
          lam_nxt = 17'h10000; cur_nxt = lo_nxt;
          v_nxt = '0; state_nxt = S_VAL_RD;
        end else if (32'(cur_r) >= 32'(rows_r) || cur_r == '0) begin
          c_nxt = '0; state_nxt = S_WALK_RD;
        end else begin
          s_raddr = cur_r - RW'(1);
          state_nxt = S_CUR_CHK;
        end
      end
      S_CUR_CHK: begin
        c_nxt = (srd >= word_r) ? '0 : cur_r;
        state_nxt = S_WALK_RD;
      end
      S_WALK_RD: begin
        s_raddr = c_r;
        state_nxt = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (32'(c_r) + 1 < 32'(rows_r) && srd < word_r) begin
          c_nxt = c_r + RW'(1);
          state_nxt = S_WALK_RD;
        end else begin
          cur_nxt = c_r; hi_nxt = c_r; lo_nxt = c_r - RW'(1);
          t2_nxt = srd; exact_nxt = (srd == word_r);
          s_raddr = c_r - RW'(1);
          state_nxt = S_LO_RD;
        end
      end
      S_LO_RD: begin
        t1_nxt = srd;
        disc_nxt = exact_r ? hi_r : lo_r;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!div_ctl.busy && !div_ctl.done && !div_start_r) div_start = 1'b1;
        if (div_ctl.done) begin
          lam_nxt = div_q;
          v_nxt = '0;
          state_nxt = S_VAL_RD;
        end
      end
      S_VAL_RD: begin
        if (!ov_r || out_ready) begin
          v_raddr = AW'(32'(is_cont ? lo_r : disc_r) * MAX_VARS + 32'(v_r));
          state_nxt = S_VAL_WAIT;
        end
      end
      S_VAL_WAIT: begin
        v1_nxt = $signed(v_rdata);
        v_raddr = AW'(32'(hi_r) * MAX_VARS + 32'(v_r));
        state_nxt = S_VAL_EMIT;
      end
      S_VAL_EMIT: begin
        ovar_nxt = v_r;
        oval_nxt = is_cont ? blended : v1_r;
        ost_nxt = ST_OK;
        olast_nxt = (v_r == n_eff);
        ov_nxt = 1'b1;
        v_nxt = v_r + 3'd1;
        state_nxt = (v_r == n_eff) ? S_IDLE : S_VAL_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) div_start_r <= 1'b0;
    else div_start_r <= div_start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rows_r   <= '0;
      cur_r    <= '0;
      ov_r     <= 1'b0;
      active_r <= 4'd8;
      mask_r   <= 8'hFF;
    end else begin
      state_r <= state_nxt;
      rows_r  <= rows_nxt;
      cur_r   <= cur_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we && cfg_index == CFG_ACTIVE) active_r <= cfg_data[3:0];
      if (cfg_we && cfg_index == CFG_MASK) mask_r <= cfg_data;
    end
    if (in_valid && in_ready) begin
      op_r <= in_op; row_r <= in_row; var_in_r <= in_variable; word_r <= in_data_word;
    end
    c_r <= c_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; disc_r <= disc_nxt;
    t1_r <= t1_nxt; t2_r <= t2_nxt; lam_r <= lam_nxt; exact_r <= exact_nxt;
    v_r <= v_nxt; v1_r <= v1_nxt;
    olast_r <= olast_nxt; ovar_r <= ovar_nxt; oval_r <= oval_nxt; ost_r <= ost_nxt;
  end

  ap_rows_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rows_r) <= MAX_ROWS) else $error("row count overflow");
  ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(oval_r)) else $error("result dropped");
  ap_noacc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("accept while busy");
endmodule
